// ===== hw/rtl/lkc_pkg.sv =====
// shared constants and types for the lru key cache
package lkc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_BITS    = 16;
  localparam int SLOT_BITS   = 8;
  localparam int CAP_BITS    = 5;
  localparam int OCC_BITS    = 5;
  localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(MAX_ENTRIES);
  localparam logic [CAP_BITS-1:0] CAP_LIMIT = CAP_BITS'(MAX_ENTRIES);

  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  // one cache entry as it moves down the row
  typedef struct packed {
    key_t  key;
    slot_t slot;
  } entry_t;

  // per-cell position flags derived from the fill count
  typedef struct packed {
    logic occupied;
    logic is_tail;
  } cell_ctl_t;

  // values rippling along the row during one lookup
  typedef struct packed {
    logic  hit_above;
    slot_t hit_slot;
    key_t  tail_key;
  } link_t;

  // request-wide controls broadcast to every cell
  typedef struct packed {
    key_t lookup_key;
    logic hit;
    logic insert;
    logic accept;
  } req_ctl_t;

endpackage

// ===== hw/rtl/lkc_in_if.sv =====
// request channel: lookup key plus backing store info
interface lkc_in_if import lkc_pkg::*; ();
  logic  valid;
  logic  ready;
  key_t  lookup_key;
  logic  key_in_store;
  slot_t store_slot;

  modport source (output valid, lookup_key, key_in_store, store_slot, input ready);
  modport sink   (input valid, lookup_key, key_in_store, store_slot, output ready);
endinterface

// ===== hw/rtl/lkc_out_if.sv =====
// result channel: one beat per request
interface lkc_out_if import lkc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                hit;
  logic                found;
  slot_t               result_slot;
  logic                evicted;
  key_t                evicted_key;
  logic [OCC_BITS-1:0] occupancy;

  modport source (output valid, hit, found, result_slot, evicted, evicted_key, occupancy,
                  input ready);
  modport sink   (input valid, hit, found, result_slot, evicted, evicted_key, occupancy,
                  output ready);
endinterface

// ===== hw/rtl/lkc_cfg_if.sv =====
// capacity register write channel
interface lkc_cfg_if import lkc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CAP_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/lkc_cell.sv =====
// one entry cell of the recency-ordered row
module lkc_cell import lkc_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  req_ctl_t  req,
  input  entry_t    prev_entry,
  input  link_t     link_in,
  output link_t     link_out,
  output entry_t    entry
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   match;
  logic   shift;

  // key compare against this entry
  assign match = ctl.occupied && (entry_r.key == req.lookup_key);

  // first-match priority, hit slot and tail key ripple down the row
  always_comb begin
    link_out.hit_above = link_in.hit_above | match;
    link_out.hit_slot  = (match && !link_in.hit_above) ? entry_r.slot : link_in.hit_slot;
    link_out.tail_key  = ctl.is_tail ? entry_r.key : link_in.tail_key;
  end

  // take the neighbor's entry on insert, or on a hit at or below this cell
  assign shift = req.accept && (req.insert || (req.hit && !link_in.hit_above));

  always_comb begin
    entry_nxt = entry_r;
    if (shift) begin
      entry_nxt = prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== hw/rtl/lru_key_cache.sv =====
// lru key cache: recency-ordered row of entry cells with move-to-front
// result beat is registered, valid in the cycle after the request beat
// throughput: one request per cycle while the result beat is not stalled; the whole row compares and shifts together
// a stalled result holds the input until the result beat is taken
// reset: fill count cleared (cache empty), capacity set to 16, no result pending
// entry contents are not cleared; cells past the fill count are never matched
module lru_key_cache import lkc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  lkc_in_if.sink     in_ch,
  lkc_out_if.source  out_ch,
  lkc_cfg_if.sink    cfg_ch
);

  logic [CAP_BITS-1:0] cap_r;
  logic [CAP_BITS-1:0] cap_nxt;
  logic [CAP_BITS-1:0] cap_eff;
  cnt_t                cnt_r;
  cnt_t                cnt_nxt;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                hit_r;
  logic                found_r;
  slot_t               rslot_r;
  logic                evicted_r;
  key_t                evkey_r;
  logic [OCC_BITS-1:0] occ_r;

  logic     accept;
  logic     hit;
  logic     insert;
  logic     evict;
  req_ctl_t req;
  entry_t   head_entry;

  link_t     links   [MAX_ENTRIES+1];
  entry_t    entries [MAX_ENTRIES];
  cell_ctl_t ctls    [MAX_ENTRIES];

  // configuration write, always ready
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cap_nxt = cap_r;
    if (cfg_ch.valid) begin
      cap_nxt = cfg_ch.data;
    end
  end

  assign cap_eff = (cap_r > CAP_LIMIT) ? CAP_LIMIT : cap_r;

  // input handshake, output register parts the two sides
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // start of the ripple chain; tail key defaults to the new key for an empty row
  assign links[0].hit_above = 1'b0;
  assign links[0].hit_slot  = '0;
  assign links[0].tail_key  = in_ch.lookup_key;

  assign hit    = links[MAX_ENTRIES].hit_above;
  assign insert = !hit && in_ch.key_in_store;
  assign evict  = insert && (({1'b0, cnt_r} + (CNT_BITS+1)'(1)) >
                             (CNT_BITS+1)'(cap_eff));

  always_comb begin
    req.lookup_key = in_ch.lookup_key;
    req.hit        = hit;
    req.insert     = insert;
    req.accept     = accept;
  end

  // front cell receives the hit entry or the new one
  always_comb begin
    head_entry.key  = in_ch.lookup_key;
    head_entry.slot = hit ? links[MAX_ENTRIES].hit_slot : in_ch.store_slot;
  end

  // row of entry cells
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign ctls[i].occupied = cnt_r > CNT_BITS'(i);
    assign ctls[i].is_tail  = cnt_r == CNT_BITS'(i + 1);

    lkc_cell u_cell (
      .clk        (clk),
      .ctl        (ctls[i]),
      .req        (req),
      .prev_entry ((i == 0) ? head_entry : entries[(i == 0) ? 0 : i - 1]),
      .link_in    (links[i]),
      .link_out   (links[i+1]),
      .entry      (entries[i])
    );
  end

  // fill count update
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && insert && !evict) begin
      cnt_nxt = cnt_r + CNT_BITS'(1);
    end
  end

  // result register control
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded on each accepted request beat
  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r     <= hit;
      found_r   <= hit || insert;
      rslot_r   <= hit ? links[MAX_ENTRIES].hit_slot :
                   (insert ? in_ch.store_slot : '0);
      evicted_r <= evict;
      evkey_r   <= evict ? links[MAX_ENTRIES].tail_key : '0;
      occ_r     <= OCC_BITS'(cnt_nxt);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = hit_r;
  assign out_ch.found       = found_r;
  assign out_ch.result_slot = rslot_r;
  assign out_ch.evicted     = evicted_r;
  assign out_ch.evicted_key = evkey_r;
  assign out_ch.occupancy   = occ_r;

endmodule
